>>> design/fmqd_pkg.sv
// fmqd_pkg: shared constants, microcode types and control store of the fm discriminator
`default_nettype none

package fmqd_pkg;

  // fixed field and datapath widths
  localparam int GAIN_W    = 16;
  localparam int OUT_W     = 16;
  localparam int GAIN_RST  = 410;
  localparam int DQW       = 23;  // ratio d, signed q6.16
  localparam int SUMW      = 21;  // c1 + rnd(d*c2)
  localparam int DENW      = 24;  // denominator, unsigned q16
  localparam int TW        = 20;  // angle t, signed q16
  localparam int QW        = 23;  // raw quotient bits
  localparam int FRAC_BITS = 17;  // fraction bits before final rounding
  localparam int INTW      = QW - FRAC_BITS;
  localparam int CNTW      = 5;
  localparam int RATIO_SH  = 5;   // ratio limit of 32
  localparam int RND_SH    = 16;

  // product slices that carry each multiply
  localparam int DC_PW = 38;  // d * c2
  localparam int DS_PW = 44;  // d * sum
  localparam int TG_PW = 37;  // t * gain

  localparam int K_C0      = 64500;
  localparam int K_C1      = 6127;
  localparam int K_C2      = 12816;
  localparam int K_HALF_PI = 102944;
  localparam int Q16_ONE   = 65536;
  localparam int RATIO_MIN = -(32 * 65536);
  localparam int OUT_MAX   = 32767;
  localparam int OUT_MIN   = -32768;

  typedef logic [4:0] step_t;

  typedef enum logic [1:0] {MA_LI, MA_LQ, MA_D, MA_T} mula_e;
  typedef enum logic [2:0] {MB_CI, MB_CQ, MB_C2, MB_SUM, MB_GAIN} mulb_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_e;
  typedef enum logic [3:0] {
    ACT_NONE, ACT_ACCEPT, ACT_SAVE_RE, ACT_SHIFT, ACT_OCTANT, ACT_DIV_STEP,
    ACT_SAVE_D, ACT_SUM, ACT_DEN, ACT_SAVE_T, ACT_OUTPUT
  } act_e;
  typedef enum logic [2:0] {
    JMP_NEXT, JMP_ALWAYS, JMP_IDLE, JMP_NODIV, JMP_DIV_LOOP, JMP_OUT_FULL
  } jmp_e;

  typedef struct packed {
    logic  mul_en;
    mula_e mul_a;
    mulb_e mul_b;
    acc_e  acc;
    act_e  act;
    jmp_e  jmp;
    step_t tgt;
  } ctrl_t;

  // program steps
  localparam step_t ST_WAIT   = 5'd0;
  localparam step_t ST_RE_A   = 5'd1;
  localparam step_t ST_RE_B   = 5'd2;
  localparam step_t ST_IM_A   = 5'd3;
  localparam step_t ST_IM_B   = 5'd4;
  localparam step_t ST_IM_SUM = 5'd5;
  localparam step_t ST_OCT    = 5'd6;
  localparam step_t ST_DIV1   = 5'd7;
  localparam step_t ST_SAVE_D = 5'd8;
  localparam step_t ST_DC     = 5'd9;
  localparam step_t ST_SUM    = 5'd10;
  localparam step_t ST_DS     = 5'd11;
  localparam step_t ST_DEN    = 5'd12;
  localparam step_t ST_DIV2   = 5'd13;
  localparam step_t ST_SAVE_T = 5'd14;
  localparam step_t ST_TG     = 5'd15;
  localparam step_t ST_OUT    = 5'd16;
  localparam step_t ST_RET    = 5'd17;

  localparam ctrl_t CW_NOP = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_NONE, JMP_NEXT, ST_WAIT};

  // control store
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t c;
    c = CW_NOP;
    case (pc)
      ST_WAIT:   c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_ACCEPT, JMP_IDLE, ST_WAIT};
      ST_RE_A:   c = '{1'b1, MA_LI, MB_CI, ACC_HOLD, ACT_NONE, JMP_NEXT, ST_WAIT};
      ST_RE_B:   c = '{1'b1, MA_LQ, MB_CQ, ACC_LOAD, ACT_NONE, JMP_NEXT, ST_WAIT};
      ST_IM_A:   c = '{1'b1, MA_LI, MB_CQ, ACC_ADD, ACT_NONE, JMP_NEXT, ST_WAIT};
      ST_IM_B:   c = '{1'b1, MA_LQ, MB_CI, ACC_LOAD, ACT_SAVE_RE, JMP_NEXT, ST_WAIT};
      ST_IM_SUM: c = '{1'b0, MA_LI, MB_CI, ACC_SUB, ACT_SHIFT, JMP_NEXT, ST_WAIT};
      ST_OCT:    c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_OCTANT, JMP_NODIV, ST_DC};
      ST_DIV1:   c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_DIV_STEP, JMP_DIV_LOOP, ST_DIV1};
      ST_SAVE_D: c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_SAVE_D, JMP_NEXT, ST_WAIT};
      ST_DC:     c = '{1'b1, MA_D, MB_C2, ACC_HOLD, ACT_NONE, JMP_NEXT, ST_WAIT};
      ST_SUM:    c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_SUM, JMP_NEXT, ST_WAIT};
      ST_DS:     c = '{1'b1, MA_D, MB_SUM, ACC_HOLD, ACT_NONE, JMP_NEXT, ST_WAIT};
      ST_DEN:    c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_DEN, JMP_NEXT, ST_WAIT};
      ST_DIV2:   c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_DIV_STEP, JMP_DIV_LOOP, ST_DIV2};
      ST_SAVE_T: c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_SAVE_T, JMP_NEXT, ST_WAIT};
      ST_TG:     c = '{1'b1, MA_T, MB_GAIN, ACC_HOLD, ACT_NONE, JMP_NEXT, ST_WAIT};
      ST_OUT:    c = '{1'b0, MA_T, MB_GAIN, ACC_HOLD, ACT_OUTPUT, JMP_OUT_FULL, ST_OUT};
      ST_RET:    c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_NONE, JMP_ALWAYS, ST_WAIT};
      default:   c = '{1'b0, MA_LI, MB_CI, ACC_HOLD, ACT_NONE, JMP_ALWAYS, ST_WAIT};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/fmqd_if.sv
// fmqd_if: valid/ready channel interfaces for iq samples in and frequency samples out
`default_nettype none

interface fmqd_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface fmqd_out_if import fmqd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] freq_sample;
  logic                    saturated;

  modport source (output valid, output freq_sample, output saturated, input ready);
  modport sink   (input valid, input freq_sample, input saturated, output ready);
endinterface

`default_nettype wire

>>> design/fm_quadrature_discriminator_unit.sv
// fm_quadrature_discriminator_unit: microcoded fm discriminator, conjugate product and arctan
//
// usage
//   samp_i carries one signed iq sample per transaction (valid/ready, taken on a clock
//   edge where both are high). freq_o returns exactly one transaction per input: the
//   signed q3.12 frequency sample and a flag that is set when the ratio or the output
//   was clipped. cfg_we_i/cfg_wdata_i write the unsigned q4.12 gain, one write per edge;
//   write it only while no sample is in flight.
//   a small sequencer walks a fixed program: four products on one shared multiplier,
//   an octant choice, a restoring divider that retires one quotient bit per cycle,
//   the rational arctan with two more products, a second division and the gain
//   product. the first division is skipped for equal parts or a clipped ratio.
//   a new sample is taken only at the wait step, so the sequencer finishes one
//   sample before it accepts the next.
//   the output register lets the next sample be accepted while a result waits; if the
//   receiver still holds off when the next result is ready, the sequencer waits.
//   reset clears the stored previous sample to zero, the gain to 410 and drops any
//   pending result.
`default_nettype none

module fm_quadrature_discriminator_unit import fmqd_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fmqd_in_if.sink           samp_i,
  fmqd_out_if.source        freq_o,
  input  logic              cfg_we_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int MulW  = (SW > DQW) ? SW : DQW;
  localparam int ProdW = 2 * MulW;
  localparam int AccW  = 2 * SW + 1;
  localparam int MagW  = 2 * SW;
  localparam int DW    = (MagW > DENW + 1) ? MagW : DENW + 1;

  localparam logic signed [DC_PW-1:0] DC_HALF = DC_PW'(1 << (RND_SH - 1));
  localparam logic signed [DS_PW-1:0] DS_HALF = DS_PW'(1 << (RND_SH - 1));
  localparam logic signed [TG_PW:0]   TG_HALF = (TG_PW + 1)'(1 << (RND_SH - 1));
  localparam logic signed [TG_PW:0]   Y_MAX   = (TG_PW + 1)'(OUT_MAX);
  localparam logic signed [TG_PW:0]   Y_MIN   = (TG_PW + 1)'(OUT_MIN);
  localparam logic signed [DS_PW-1:0] DEN_MIN = DS_PW'(1);

  // sequencer
  step_t pc_q, pc_d;
  ctrl_t cw;
  logic  accept;
  logic  jump;

  // sample and config state
  logic signed [SW-1:0] last_i_q, last_q_q, cur_i_q, cur_q_q;
  logic [GAIN_W-1:0]    gain_q;

  // datapath
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_prod, re_q;
  logic signed [DQW-1:0]   d_q;
  logic signed [SUMW-1:0]  sum_q;
  logic signed [TW-1:0]    t_q;
  logic                    ang_q, neg_q, sat_q, div_neg_q;

  // serial divider
  logic [DW-1:0]   rem_q, dvsr_q;
  logic [INTW-1:0] nbits_q;
  logic [QW-1:0]   quo_q;
  logic [CNTW-1:0] cnt_q;

  // output register
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] freq_q;
  logic                    osat_q;

  assign cw            = ucode(pc_q);
  assign samp_i.ready  = (cw.act == ACT_ACCEPT);
  assign accept        = samp_i.valid && samp_i.ready;
  assign freq_o.valid       = out_valid_q;
  assign freq_o.freq_sample = freq_q;
  assign freq_o.saturated   = osat_q;

  // multiplier operand select
  always_comb begin
    case (cw.mul_a)
      MA_LI:   mul_a = MulW'(last_i_q);
      MA_LQ:   mul_a = MulW'(last_q_q);
      MA_D:    mul_a = MulW'(d_q);
      MA_T:    mul_a = MulW'(t_q);
      default: mul_a = '0;
    endcase
    case (cw.mul_b)
      MB_CI:   mul_b = MulW'(cur_i_q);
      MB_CQ:   mul_b = MulW'(cur_q_q);
      MB_C2:   mul_b = MulW'(K_C2);
      MB_SUM:  mul_b = MulW'(sum_q);
      MB_GAIN: mul_b = MulW'($signed({1'b0, gain_q}));
      default: mul_b = '0;
    endcase
  end

  // sample products fit in 2*SW bits
  assign acc_prod = {prod_q[MagW-1], prod_q[MagW-1:0]};

  // octant choice on re and im
  logic signed [AccW-1:0] im_abs, re_abs;
  logic [MagW-1:0]        im_mag, re_mag;
  logic [MagW+RATIO_SH-1:0] im_x32;
  logic                   oct_nodiv, oct_ang, oct_neg, oct_sat, oct_dneg;
  logic signed [DQW-1:0]  oct_d;
  logic [MagW-1:0]        oct_a, oct_b;

  always_comb begin
    im_abs    = acc_q[AccW-1] ? -acc_q : acc_q;
    re_abs    = re_q[AccW-1] ? -re_q : re_q;
    im_mag    = im_abs[MagW-1:0];
    re_mag    = re_abs[MagW-1:0];
    im_x32    = {im_mag, {RATIO_SH{1'b0}}};
    oct_nodiv = 1'b0;
    oct_ang   = 1'b0;
    oct_neg   = acc_q[AccW-1];
    oct_sat   = 1'b0;
    oct_dneg  = 1'b0;
    oct_d     = DQW'(Q16_ONE);
    oct_a     = im_mag;
    oct_b     = re_mag;
    if (re_q == im_abs) begin
      oct_nodiv = 1'b1;
    end else if (re_q > im_abs) begin
      oct_a = im_mag;
      oct_b = re_mag;
    end else begin
      oct_ang = 1'b1;
      oct_neg = !acc_q[AccW-1];
      oct_a   = re_mag;
      oct_b   = im_mag;
      if (re_q[AccW-1]) begin
        oct_dneg = 1'b1;
        // ratio below -32, also a zero divisor
        if ({{RATIO_SH{1'b0}}, re_mag} > im_x32) begin
          oct_sat   = 1'b1;
          oct_nodiv = 1'b1;
          oct_d     = DQW'(RATIO_MIN);
        end
      end
    end
  end

  // divider step and load
  logic [DW:0]     trial, diff;
  logic            ge;
  logic [QW:0]     q_inc;
  logic signed [DQW-1:0] q_s, f_s;
  logic [DQW-1:0]  d_mag;
  logic            div_load;
  logic [DW-1:0]   div_a, div_b;
  logic            div_neg_d;

  // arctan arithmetic on the product register
  logic signed [DC_PW-1:0] p_dc, r_dc;
  logic signed [DS_PW-1:0] p_ds, r_ds, den_full;
  logic [DENW-1:0]         den_v;
  logic signed [TG_PW:0]   p_tg, y_full;
  logic signed [OUT_W-1:0] y_v;
  logic                    y_clip;

  always_comb begin
    trial = {rem_q, nbits_q[INTW-1]};
    diff  = trial - {1'b0, dvsr_q};
    ge    = (trial >= {1'b0, dvsr_q});
    q_inc = {1'b0, quo_q} + {{QW{1'b0}}, 1'b1};
    q_s   = q_inc[QW:1];
    f_s   = div_neg_q ? -q_s : q_s;
    d_mag = d_q[DQW-1] ? DQW'(-d_q) : DQW'(d_q);

    p_dc = prod_q[DC_PW-1:0];
    r_dc = (p_dc + DC_HALF) >>> RND_SH;
    p_ds = prod_q[DS_PW-1:0];
    r_ds = (p_ds + DS_HALF) >>> RND_SH;
    den_full = r_ds + DS_PW'(K_C0);
    if (den_full < DEN_MIN) begin
      den_full = DEN_MIN;
    end
    den_v = den_full[DENW-1:0];

    p_tg = (TG_PW + 1)'($signed(prod_q[TG_PW-1:0]));
    if (neg_q) begin
      p_tg = -p_tg;
    end
    y_full = (p_tg + TG_HALF) >>> RND_SH;
    y_clip = 1'b1;
    if (y_full > Y_MAX) begin
      y_v = OUT_W'(OUT_MAX);
    end else if (y_full < Y_MIN) begin
      y_v = OUT_W'(OUT_MIN);
    end else begin
      y_v    = y_full[OUT_W-1:0];
      y_clip = 1'b0;
    end

    div_load  = 1'b0;
    div_a     = DW'(oct_a);
    div_b     = DW'(oct_b);
    div_neg_d = oct_dneg;
    if (cw.act == ACT_OCTANT) begin
      div_load = 1'b1;
    end else if (cw.act == ACT_DEN) begin
      div_load  = 1'b1;
      div_a     = DW'(d_mag);
      div_b     = DW'(den_v);
      div_neg_d = d_q[DQW-1];
    end
  end

  // next step
  always_comb begin
    case (cw.jmp)
      JMP_NEXT:     jump = 1'b0;
      JMP_ALWAYS:   jump = 1'b1;
      JMP_IDLE:     jump = !accept;
      JMP_NODIV:    jump = oct_nodiv;
      JMP_DIV_LOOP: jump = (cnt_q != '0);
      JMP_OUT_FULL: jump = out_valid_q && !freq_o.ready;
      default:      jump = 1'b1;
    endcase
    pc_d = jump ? cw.tgt : step_t'(pc_q + step_t'(1));
  end

  // control state, stored sample, gain and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_WAIT;
      last_i_q    <= '0;
      last_q_q    <= '0;
      gain_q      <= GAIN_W'(GAIN_RST);
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (cw.act == ACT_SHIFT) begin
        last_i_q <= cur_i_q;
        last_q_q <= cur_q_q;
      end
      // a new result takes priority over the drain of the old one
      if (cw.act == ACT_OUTPUT && !(out_valid_q && !freq_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (freq_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_i_q <= samp_i.sample_i;
      cur_q_q <= samp_i.sample_q;
    end
    if (cw.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cw.acc)
      ACC_HOLD: acc_q <= acc_q;
      ACC_LOAD: acc_q <= acc_prod;
      ACC_ADD:  acc_q <= acc_q + acc_prod;
      ACC_SUB:  acc_q <= acc_q - acc_prod;
      default:  acc_q <= acc_q;
    endcase
    if (cw.act == ACT_SAVE_RE) begin
      re_q <= acc_q;
    end
    if (cw.act == ACT_OCTANT) begin
      d_q   <= oct_d;
      ang_q <= oct_ang;
      neg_q <= oct_neg;
      sat_q <= oct_sat;
    end
    if (div_load) begin
      rem_q     <= div_a >> INTW;
      nbits_q   <= div_a[INTW-1:0];
      dvsr_q    <= div_b;
      quo_q     <= '0;
      cnt_q     <= CNTW'(QW - 1);
      div_neg_q <= div_neg_d;
    end else if (cw.act == ACT_DIV_STEP) begin
      rem_q   <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nbits_q <= {nbits_q[INTW-2:0], 1'b0};
      quo_q   <= {quo_q[QW-2:0], ge};
      cnt_q   <= cnt_q - CNTW'(1);
    end
    if (cw.act == ACT_SAVE_D) begin
      d_q <= f_s;
    end
    if (cw.act == ACT_SUM) begin
      sum_q <= SUMW'(r_dc) + SUMW'(K_C1);
    end
    if (cw.act == ACT_SAVE_T) begin
      t_q <= TW'(f_s) - (ang_q ? TW'(K_HALF_PI) : TW'(0));
    end
    if (cw.act == ACT_OUTPUT && !(out_valid_q && !freq_o.ready)) begin
      freq_q <= y_v;
      osat_q <= sat_q || y_clip;
    end
  end

  // checks
  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.act == ACT_DIV_STEP) |-> (rem_q < dvsr_q))
    else $error("divider remainder not below divisor");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (pc_q == ST_RE_A))
    else $error("sequencer did not start after an accepted sample");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(pc_q) == ST_OUT))
    else $error("result raised outside the output step");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.act == ACT_OUTPUT && out_valid_q && !freq_o.ready) |=>
      (pc_q == ST_OUT) && $stable(freq_q) && $stable(osat_q))
    else $error("pending result overwritten");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cw.act == ACT_SAVE_D) |->
      ((d_q <= DQW'(Q16_ONE)) && (d_q >= DQW'(RATIO_MIN))))
    else $error("ratio out of range");

endmodule

`default_nettype wire

>>> sim/fmqd_freq_checker.sv
// fmqd_freq_checker: predicts each frequency sample of the discriminator and compares it at the output
`timescale 1ns / 100ps

module fmqd_freq_checker import fmqd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  fmqd_in_if                samp_mon,
  fmqd_out_if               freq_mon,
  input  logic              cfg_we_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i,
  output int                fail_count,
  output int                pending,
  output int                results_checked,
  output int                clips_seen
);

  localparam int SW = 16;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic signed [OUT_W-1:0] freq;
    logic                    clip;
  } freq_result_t;

  freq_result_t        predicted_freq_q [$];
  freq_result_t        want;
  logic signed [SW-1:0] prev_i, prev_q;
  logic [GAIN_W-1:0]   gain_now;

  // round to nearest at bit 16, ties toward +inf
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // a/b in q16, ties away from zero on magnitudes
  function automatic longint q16_ratio(input longint a, input longint b);
    return (((a <<< 17) / b) + 64'sd1) >>> 1;
  endfunction

  function automatic freq_result_t discriminate(input logic signed [SW-1:0] cur_i, cur_q,
                                                input logic signed [SW-1:0] old_i, old_q,
                                                input logic [GAIN_W-1:0] gain);
    longint       re, im, d, den, f, t, p, y, ang;
    bit           flip, clip;
    freq_result_t r;
    re   = longint'(old_i) * longint'(cur_i) + longint'(old_q) * longint'(cur_q);
    im   = longint'(old_i) * longint'(cur_q) - longint'(cur_i) * longint'(old_q);
    flip = 1'b0;
    clip = 1'b0;
    ang  = 0;
    if (im < 0) begin
      flip = 1'b1;
      im   = -im;
    end
    if (re == im) begin
      d = Q16_ONE;
    end else if (re > im) begin
      d = q16_ratio(im, re);
    end else begin
      // other octant: angle measured from -pi/2, sense reversed
      ang  = -K_HALF_PI;
      flip = !flip;
      if (re >= 0) begin
        d = q16_ratio(re, im);
      end else if (-re > im * 32) begin
        clip = 1'b1;
        d    = RATIO_MIN;
      end else begin
        d = -q16_ratio(-re, im);
      end
    end
    den = K_C0 + round_q16(d * (K_C1 + round_q16(d * K_C2)));
    if (den < 1) den = 1;
    f = (d < 0) ? -q16_ratio(-d, den) : q16_ratio(d, den);
    t = ang + f;
    p = t * longint'(gain);
    if (flip) p = -p;
    y = round_q16(p);
    if (y > OUT_MAX) begin
      y    = OUT_MAX;
      clip = 1'b1;
    end else if (y < OUT_MIN) begin
      y    = OUT_MIN;
      clip = 1'b1;
    end
    r.freq = y[OUT_W-1:0];
    r.clip = clip;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_freq_q.delete();
      prev_i          = '0;
      prev_q          = '0;
      gain_now        = GAIN_W'(GAIN_RST);
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
      clips_seen      = 0;
    end else begin
      if (freq_mon.valid && freq_mon.ready) begin
        results_checked++;
        if (freq_mon.saturated) clips_seen++;
        if (predicted_freq_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected frequency sample %0d sat %0b, nothing expected",
                     $time, freq_mon.freq_sample, freq_mon.saturated);
        end else begin
          want = predicted_freq_q.pop_front();
          if (freq_mon.freq_sample !== want.freq || freq_mon.saturated !== want.clip) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch freq_sample expected %0d got %0d, saturated expected %0b got %0b",
                       $time, want.freq, freq_mon.freq_sample, want.clip, freq_mon.saturated);
          end
        end
      end
      if (samp_mon.valid && samp_mon.ready) begin
        predicted_freq_q.push_back(discriminate(samp_mon.sample_i, samp_mon.sample_q,
                                                prev_i, prev_q, gain_now));
        prev_i = samp_mon.sample_i;
        prev_q = samp_mon.sample_q;
      end
      if (cfg_we_i) gain_now = cfg_wdata_i;
      pending = predicted_freq_q.size();
    end
  end

endmodule

>>> sim/fm_quadrature_discriminator_unit_tb.sv
// fm_quadrature_discriminator_unit_tb: stimulus, flow control and verdict for the fm discriminator
`timescale 1ns / 100ps

module fm_quadrature_discriminator_unit_tb;
  import fmqd_pkg::*;

  localparam int SW             = 16;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLDOFF_CYCLES = 300;
  // quiet tail after the final drain; a drained block settles well within it
  localparam int TAIL_CYCLES    = 100;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [GAIN_W-1:0] cfg_wdata_i;

  int fail_count, pending, results_checked, clips_seen;
  int items_sent;
  int send_idle_pct, stall_pct;
  int holdoff_req, holdoff_done;

  // last sample sent, used to build related follow-on samples
  logic signed [SW-1:0] last_i, last_q;
  logic signed [SW-1:0] next_i, next_q;
  logic [GAIN_W-1:0]    phase_gain;
  logic signed [SW-1:0] corner_vals [5] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};

  fmqd_in_if #(.SAMPLE_WIDTH(SW)) samp_ch ();
  fmqd_out_if                     freq_ch ();

  fm_quadrature_discriminator_unit #(.SAMPLE_WIDTH(SW)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .samp_i     (samp_ch),
    .freq_o     (freq_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  fmqd_freq_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .samp_mon       (samp_ch),
    .freq_mon       (freq_ch),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .clips_seen     (clips_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // saturate a wide value into the sample range
  function automatic logic signed [SW-1:0] clamp_sample(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[SW-1:0];
  endfunction

  // receiver: random stalls, plus a long hold-off when the stimulus asks for one
  initial begin
    freq_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holdoff_req != holdoff_done) begin
        // hold ready low for the whole stretch, counted here
        freq_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk_i);
        holdoff_done = holdoff_req;
      end else begin
        freq_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one transaction on the sample channel; entered and left just after a falling edge,
  // valid stays high on exit so back-to-back transactions need no second assignment
  task automatic push_sample(input logic signed [SW-1:0] si, input logic signed [SW-1:0] sq);
    while ($urandom_range(99) < send_idle_pct) begin
      samp_ch.valid    <= 1'b0;
      samp_ch.sample_i <= SW'($urandom);
      samp_ch.sample_q <= SW'($urandom);
      @(negedge clk_i);
    end
    samp_ch.valid    <= 1'b1;
    samp_ch.sample_i <= si;
    samp_ch.sample_q <= sq;
    @(posedge clk_i);
    while (!samp_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    last_i = si;
    last_q = sq;
  endtask

  // stop offering samples and wait until every predicted result has come back
  task automatic drain_block();
    samp_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // gain is only written with nothing in flight
  task automatic write_gain(input logic [GAIN_W-1:0] g);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    samp_ch.valid    = 1'b0;
    samp_ch.sample_i = '0;
    samp_ch.sample_q = '0;
    items_sent       = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    holdoff_req      = 0;
    holdoff_done     = 0;
    last_i           = '0;
    last_q           = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, reset gain first
    push_sample(16'sh7fff, 16'sd0);       // previous sample is zero: equal parts, both zero
    push_sample(16'sh7fff, 16'sd0);       // no rotation, zero imaginary part
    push_sample(16'sh8000, 16'sd0);       // half turn: zero divisor with negative real part
    push_sample(16'sh8000, 16'sh8000);    // real and imaginary parts equal and nonzero
    push_sample(16'sh7fff, 16'sh8000);    // full-scale corners, ratio near zero
    // quarter turns counterclockwise, then clockwise
    push_sample(16'sd1000, 16'sd0);
    push_sample(16'sd0, 16'sd1000);
    push_sample(-16'sd1000, 16'sd0);
    push_sample(16'sd0, -16'sd1000);
    push_sample(16'sd1000, 16'sd0);
    push_sample(16'sd0, -16'sd1000);
    push_sample(16'sd1000, 16'sd0);
    push_sample(-16'sd32000, 16'sd1000);  // ratio exactly at the -32 limit, not clipped
    push_sample(16'sd1000, 16'sd0);
    push_sample(-16'sd32001, 16'sd1000);  // ratio just beyond the limit, clipped
    push_sample(16'sd1000, 16'sd0);
    push_sample(-16'sd1000, -16'sd1);     // near half turn with negative imaginary part
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sh7fff, 16'sh7fff);

    // largest gain: most nonzero angles clip the output
    write_gain(16'hffff);
    push_sample(16'sd0, 16'sh7fff);
    push_sample(16'sh8000, 16'sd0);
    push_sample(16'sh8000, 16'sd0);       // no rotation stays unclipped
    push_sample(16'sd7, 16'sd7);

    // random part: gain, sender idling and receiver stalls change per phase
    for (int k = 0; k < PHASES; k++) begin
      case (k)
        0:       phase_gain = 16'd4096;
        1:       phase_gain = 16'd1;
        2:       phase_gain = 16'hffff;
        3:       phase_gain = 16'd0;
        4:       phase_gain = 16'd20000;
        5:       phase_gain = 16'd410;
        default: phase_gain = GAIN_W'($urandom);
      endcase
      write_gain(phase_gain);
      case (k % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while the sender keeps going, so the block backs up
        if (k == 0 && n == 100) holdoff_req++;
        // sender pause until everything in flight has come out
        if (k == 1 && n == 125) drain_block();
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            next_i = SW'($urandom);
            next_q = SW'($urandom);
          end
          4, 5: begin
            // slow drift: small phase steps, ratio well inside range
            next_i = clamp_sample(longint'(last_i) + int'($urandom_range(4000)) - 2000);
            next_q = clamp_sample(longint'(last_q) + int'($urandom_range(4000)) - 2000);
          end
          6: begin
            // tiny values: exact ties, zero products, equal parts
            next_i = SW'(int'($urandom_range(6)) - 3);
            next_q = SW'(int'($urandom_range(6)) - 3);
          end
          7: begin
            next_i = corner_vals[$urandom_range(4)];
            next_q = corner_vals[$urandom_range(4)];
          end
          8: begin
            // near half turn: large negative real part, ratio near or past the limit
            next_i = clamp_sample(-longint'(last_i) + int'($urandom_range(80)) - 40);
            next_q = clamp_sample(-longint'(last_q) + int'($urandom_range(80)) - 40);
          end
          default: begin
            // near quarter turn in either sense: other octant
            if ($urandom_range(1)) begin
              next_i = clamp_sample(-longint'(last_q) + int'($urandom_range(200)) - 100);
              next_q = clamp_sample(longint'(last_i) + int'($urandom_range(200)) - 100);
            end else begin
              next_i = clamp_sample(longint'(last_q) + int'($urandom_range(200)) - 100);
              next_q = clamp_sample(-longint'(last_i) + int'($urandom_range(200)) - 100);
            end
          end
        endcase
        push_sample(next_i, next_q);
      end
    end

    // let everything come out, then a quiet tail to catch stray results
    drain_block();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d iq samples over %0d gain and flow-control phases", items_sent, PHASES);
    $display("checked %0d frequency samples, %0d of them clipped", results_checked, clips_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fmqd_pkg.sv
design/fmqd_if.sv
design/fm_quadrature_discriminator_unit.sv
sim/fmqd_freq_checker.sv
sim/fm_quadrature_discriminator_unit_tb.sv
